// File: rtl/assert_macros.svh
// Assertion macros used by the engine RTL of the route and ARP resolve engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAE_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rae_pkg.sv
// Package with the types, codes and helpers of the route and ARP resolve engine.
package rae_pkg;

  // Default table depths.
  localparam int ROUTE_DEPTH_DEF = 16;
  localparam int PORT_DEPTH_DEF  = 4;
  localparam int CACHE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Results per input item at most.
  localparam int MAX_RESULTS = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROUTING_ENABLED = 2'd0;
  localparam logic [1:0] REG_ROUTE_COUNT     = 2'd1;
  localparam logic [1:0] REG_PORT_COUNT      = 2'd2;

  // Input item operations.
  typedef enum logic [1:0] {
    OP_LOAD_ROUTE = 2'd0,
    OP_LOAD_IF    = 2'd1,
    OP_PACKET     = 2'd2,
    OP_ARP        = 2'd3
  } op_t;

  // Result kinds.
  typedef enum logic [2:0] {
    K_IP_FRAME   = 3'd0,
    K_ARP_REQ    = 3'd1,
    K_ARP_REPLY  = 3'd2,
    K_LOCAL      = 3'd3,
    K_NO_ROUTE   = 3'd4,
    K_QUEUE_FULL = 3'd5,
    K_DROPPED    = 3'd6,
    K_DONE       = 3'd7
  } kind_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_PT_RD, S_PT_CMP, S_RT_RD, S_RT_CMP, S_RP_RD, S_RP_CMP,
    S_CH_RD, S_CH_CMP, S_WQ_FREE, S_ARPQ, S_LN_RD, S_LN_CMP, S_LN_END,
    S_RL_RD, S_RL_CMP, S_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [31:0] ip_a;
    logic [31:0] ip_b;
    logic [31:0] ip_c;
    logic [1:0]  port_index;
    logic [47:0] mac_value;
    logic [15:0] packet_tag;
    logic        from_network;
    logic        arp_is_request;
  } item_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  out_port;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] hop_ip;
    logic [15:0] tag_out;
    logic        last;
  } item_out_t;

  typedef struct packed {
    logic       routing_enabled;
    logic [4:0] route_count;
    logic [2:0] port_count;
  } cfg_t;

  // Route table entry.
  typedef struct packed {
    logic [31:0] subnet;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [1:0]  port;
  } rt_ent_t;

  // Port table and ARP cache entry.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } nb_ent_t;

  // Pending packet entry.
  typedef struct packed {
    logic [31:0] hop;
    logic [15:0] tag;
  } wq_ent_t;

  // Builds a result that is not marked last.
  function automatic item_out_t mk_res(kind_t k, logic [1:0] port, logic [47:0] smac,
                                       logic [47:0] dmac, logic [31:0] sip,
                                       logic [31:0] dip, logic [31:0] hop,
                                       logic [15:0] tag);
    item_out_t r;
    r.kind     = k;
    r.out_port = port;
    r.src_mac  = smac;
    r.dst_mac  = dmac;
    r.src_ip   = sip;
    r.dst_ip   = dip;
    r.hop_ip   = hop;
    r.tag_out  = tag;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/rae_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rae_engine.sv
// Sequencer that walks the route, port, cache and pending tables for each packet or ARP message.
`include "assert_macros.svh"

module rae_engine #(
  parameter int ROUTE_DEPTH = rae_pkg::ROUTE_DEPTH_DEF,
  parameter int PORT_DEPTH  = rae_pkg::PORT_DEPTH_DEF,
  parameter int CACHE_DEPTH = rae_pkg::CACHE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = rae_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rae_pkg::item_in_t   in_item,
  input  rae_pkg::cfg_t       cfg,
  input  logic                out_free,
  output logic                push,
  output rae_pkg::item_out_t  push_res
);

  localparam int RA_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int PA_W = (PORT_DEPTH > 1) ? $clog2(PORT_DEPTH) : 1;
  localparam int CA_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int MAXD01 = (ROUTE_DEPTH > PORT_DEPTH) ? ROUTE_DEPTH : PORT_DEPTH;
  localparam int MAXD23 = (CACHE_DEPTH > QUEUE_DEPTH) ? CACHE_DEPTH : QUEUE_DEPTH;
  localparam int MAXD = (MAXD01 > MAXD23) ? MAXD01 : MAXD23;
  localparam int IW0 = $clog2(MAXD + 1);
  localparam int IW = (IW0 > 5) ? IW0 : 5;
  localparam logic [IW-1:0] RDEP = IW'(ROUTE_DEPTH);
  localparam logic [IW-1:0] PDEP = IW'(PORT_DEPTH);
  localparam logic [IW-1:0] CDEP = IW'(CACHE_DEPTH);
  localparam logic [IW-1:0] QDEP = IW'(QUEUE_DEPTH);
  localparam logic [4:0] MAXR = 5'(rae_pkg::MAX_RESULTS);
  localparam logic [CA_W-1:0] VICTIM_LAST = CA_W'(CACHE_DEPTH - 1);

  rae_pkg::state_t    state, state_next;
  rae_pkg::item_in_t  it, it_next;
  logic [IW-1:0]      idx, idx_next;
  logic [4:0]         res_n, res_n_next;
  logic [1:0]         p_port, p_port_next;
  logic [47:0]        p_mac, p_mac_next;
  logic [31:0]        hop, hop_next;
  logic [1:0]         rport, rport_next;
  logic [31:0]        r_ip, r_ip_next;
  logic [47:0]        r_mac, r_mac_next;
  logic               free_found, free_found_next;
  logic [CA_W-1:0]    free_idx, free_idx_next;
  logic [CA_W-1:0]    victim, victim_next;
  rae_pkg::item_out_t stg, stg_next;
  logic               stg_valid, stg_valid_next;
  logic [CACHE_DEPTH-1:0] cvalid;
  logic [QUEUE_DEPTH-1:0] wvalid;
  logic               cv_set, wv_set, wv_clr;

  logic               in_acc, can_emit, produce;
  rae_pkg::item_out_t new_res;
  logic [31:0]        key;
  logic [IW-1:0]      n_routes, n_ports;
  logic [CA_W-1:0]    ci;
  logic [QA_W-1:0]    qi;

  logic               rt_we, pt_we, ch_we, wq_we;
  logic [RA_W-1:0]    rt_waddr, rt_raddr;
  logic [PA_W-1:0]    pt_waddr, pt_raddr;
  logic [CA_W-1:0]    ch_waddr, ch_raddr;
  logic [QA_W-1:0]    wq_waddr, wq_raddr;
  rae_pkg::rt_ent_t   rt_wdata, rt_rdata;
  rae_pkg::nb_ent_t   pt_wdata, pt_rdata, ch_wdata, ch_rdata;
  rae_pkg::wq_ent_t   wq_wdata, wq_rdata;

  // Table memories.
  rae_ram #(.WIDTH($bits(rae_pkg::rt_ent_t)), .DEPTH(ROUTE_DEPTH)) u_rt_ram (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .raddr(rt_raddr), .rdata(rt_rdata)
  );
  rae_ram #(.WIDTH($bits(rae_pkg::nb_ent_t)), .DEPTH(PORT_DEPTH)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );
  rae_ram #(.WIDTH($bits(rae_pkg::nb_ent_t)), .DEPTH(CACHE_DEPTH)) u_ch_ram (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );
  rae_ram #(.WIDTH($bits(rae_pkg::wq_ent_t)), .DEPTH(QUEUE_DEPTH)) u_wq_ram (
    .clk(clk), .we(wq_we), .waddr(wq_waddr), .wdata(wq_wdata),
    .raddr(wq_raddr), .rdata(wq_rdata)
  );

  // Fixed addressing and write data.
  assign in_stall = (state != rae_pkg::S_IDLE);
  assign in_acc   = in_valid && (state == rae_pkg::S_IDLE);
  assign can_emit = !stg_valid || out_free;
  assign key      = (it.op == rae_pkg::OP_ARP) ? it.ip_b : it.ip_a;
  assign ci       = idx[CA_W-1:0];
  assign qi       = idx[QA_W-1:0];
  assign n_routes = (IW'(cfg.route_count) > RDEP) ? RDEP : IW'(cfg.route_count);
  assign n_ports  = (IW'(cfg.port_count) > PDEP) ? PDEP : IW'(cfg.port_count);

  assign rt_waddr = RA_W'(in_item.slot);
  assign rt_wdata = '{subnet: in_item.ip_a, mask: in_item.ip_b, hop: in_item.ip_c,
                      port: in_item.port_index};
  assign rt_raddr = idx[RA_W-1:0];
  assign pt_waddr = PA_W'(in_item.slot);
  assign pt_wdata = '{ip: in_item.ip_a, mac: in_item.mac_value};
  assign pt_raddr = (state == rae_pkg::S_RP_RD || state == rae_pkg::S_RP_CMP) ?
                    PA_W'(rport) : idx[PA_W-1:0];
  assign ch_wdata = '{ip: it.ip_a, mac: it.mac_value};
  assign ch_raddr = ci;
  assign wq_waddr = qi;
  assign wq_wdata = '{hop: hop, tag: it.packet_tag};
  assign wq_raddr = qi;

  // Next state, table writes and result production.
  always_comb begin
    state_next      = state;
    it_next         = it;
    idx_next        = idx;
    res_n_next      = res_n;
    p_port_next     = p_port;
    p_mac_next      = p_mac;
    hop_next        = hop;
    rport_next      = rport;
    r_ip_next       = r_ip;
    r_mac_next      = r_mac;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    victim_next     = victim;
    rt_we           = 1'b0;
    pt_we           = 1'b0;
    ch_we           = 1'b0;
    ch_waddr        = ci;
    wq_we           = 1'b0;
    cv_set          = 1'b0;
    wv_set          = 1'b0;
    wv_clr          = 1'b0;
    produce         = 1'b0;
    new_res         = '0;

    case (state)
      rae_pkg::S_IDLE: begin
        if (in_acc) begin
          it_next         = in_item;
          idx_next        = '0;
          res_n_next      = '0;
          free_found_next = 1'b0;
          case (rae_pkg::op_t'(in_item.op))
            rae_pkg::OP_LOAD_ROUTE: begin
              rt_we      = (IW'(in_item.slot) < RDEP);
              produce    = 1'b1;
              new_res    = rae_pkg::mk_res(rae_pkg::K_DONE, '0, '0, '0, '0, '0, '0, '0);
              state_next = rae_pkg::S_FLUSH;
            end
            rae_pkg::OP_LOAD_IF: begin
              pt_we      = (IW'(in_item.slot) < PDEP);
              produce    = 1'b1;
              new_res    = rae_pkg::mk_res(rae_pkg::K_DONE, '0, '0, '0, '0, '0, '0, '0);
              state_next = rae_pkg::S_FLUSH;
            end
            rae_pkg::OP_PACKET: begin
              state_next = in_item.from_network ? rae_pkg::S_PT_RD : rae_pkg::S_RT_RD;
            end
            default: begin
              state_next = rae_pkg::S_PT_RD;
            end
          endcase
        end
      end

      // Port IP search.
      rae_pkg::S_PT_RD: begin
        if (idx >= n_ports) begin
          if (it.op == rae_pkg::OP_PACKET && cfg.routing_enabled) begin
            idx_next   = '0;
            state_next = rae_pkg::S_RT_RD;
          end else begin
            produce    = 1'b1;
            new_res    = rae_pkg::mk_res(rae_pkg::K_DROPPED, '0, '0, '0, '0, '0, '0,
                             (it.op == rae_pkg::OP_PACKET) ? it.packet_tag : 16'd0);
            state_next = rae_pkg::S_FLUSH;
          end
        end else begin
          state_next = rae_pkg::S_PT_CMP;
        end
      end
      rae_pkg::S_PT_CMP: begin
        if (pt_rdata.ip == key) begin
          p_port_next = idx[1:0];
          p_mac_next  = pt_rdata.mac;
          if (it.op == rae_pkg::OP_PACKET) begin
            produce    = 1'b1;
            new_res    = rae_pkg::mk_res(rae_pkg::K_LOCAL, idx[1:0], '0, '0, '0, '0, '0,
                                         it.packet_tag);
            state_next = rae_pkg::S_FLUSH;
          end else begin
            idx_next        = '0;
            free_found_next = 1'b0;
            state_next      = rae_pkg::S_LN_RD;
          end
        end else begin
          idx_next   = idx + IW'(1);
          state_next = rae_pkg::S_PT_RD;
        end
      end

      // First-match route search.
      rae_pkg::S_RT_RD: begin
        if (idx >= n_routes) begin
          produce    = 1'b1;
          new_res    = rae_pkg::mk_res(rae_pkg::K_NO_ROUTE, '0, '0, '0, '0, '0, '0,
                                       it.packet_tag);
          state_next = rae_pkg::S_FLUSH;
        end else begin
          state_next = rae_pkg::S_RT_CMP;
        end
      end
      rae_pkg::S_RT_CMP: begin
        if ((it.ip_a & rt_rdata.mask) == rt_rdata.subnet) begin
          hop_next   = (rt_rdata.hop != 32'd0) ? rt_rdata.hop : it.ip_a;
          rport_next = rt_rdata.port;
          state_next = rae_pkg::S_RP_RD;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = rae_pkg::S_RT_RD;
        end
      end

      // Outgoing port address lookup.
      rae_pkg::S_RP_RD: begin
        state_next = rae_pkg::S_RP_CMP;
      end
      rae_pkg::S_RP_CMP: begin
        if (IW'(rport) < PDEP) begin
          r_ip_next  = pt_rdata.ip;
          r_mac_next = pt_rdata.mac;
        end else begin
          r_ip_next  = '0;
          r_mac_next = '0;
        end
        idx_next   = '0;
        state_next = rae_pkg::S_CH_RD;
      end

      // ARP cache lookup of the next hop.
      rae_pkg::S_CH_RD: begin
        if (idx >= CDEP) begin
          idx_next   = '0;
          state_next = rae_pkg::S_WQ_FREE;
        end else if (!cvalid[ci]) begin
          idx_next = idx + IW'(1);
        end else begin
          state_next = rae_pkg::S_CH_CMP;
        end
      end
      rae_pkg::S_CH_CMP: begin
        if (ch_rdata.ip == hop) begin
          produce    = 1'b1;
          new_res    = rae_pkg::mk_res(rae_pkg::K_IP_FRAME, rport, r_mac, ch_rdata.mac,
                                       '0, '0, hop, it.packet_tag);
          state_next = rae_pkg::S_FLUSH;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = rae_pkg::S_CH_RD;
        end
      end

      // Park the packet in the first free pending slot, or report a full queue; then send the ARP request.
      rae_pkg::S_WQ_FREE: begin
        if (idx >= QDEP) begin
          produce    = 1'b1;
          new_res    = rae_pkg::mk_res(rae_pkg::K_QUEUE_FULL, rport, '0, '0, '0, '0, hop,
                                       it.packet_tag);
          state_next = rae_pkg::S_ARPQ;
        end else if (!wvalid[qi]) begin
          wq_we      = 1'b1;
          wv_set     = 1'b1;
          state_next = rae_pkg::S_ARPQ;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      rae_pkg::S_ARPQ: begin
        if (can_emit) begin
          produce    = 1'b1;
          new_res    = rae_pkg::mk_res(rae_pkg::K_ARP_REQ, rport, r_mac, '0, r_ip, hop,
                                       hop, it.packet_tag);
          state_next = rae_pkg::S_FLUSH;
        end
      end

      // Learn the ARP sender: update in place, else first free, else victim.
      rae_pkg::S_LN_RD: begin
        if (idx >= CDEP) begin
          ch_we  = 1'b1;
          cv_set = 1'b1;
          if (free_found) begin
            ch_waddr = free_idx;
          end else begin
            ch_waddr    = victim;
            victim_next = (victim == VICTIM_LAST) ? '0 : victim + CA_W'(1);
          end
          state_next = rae_pkg::S_LN_END;
        end else if (!cvalid[ci]) begin
          if (!free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = ci;
          end
          idx_next = idx + IW'(1);
        end else begin
          state_next = rae_pkg::S_LN_CMP;
        end
      end
      rae_pkg::S_LN_CMP: begin
        if (ch_rdata.ip == it.ip_a) begin
          ch_we      = 1'b1;
          state_next = rae_pkg::S_LN_END;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = rae_pkg::S_LN_RD;
        end
      end
      rae_pkg::S_LN_END: begin
        if (it.arp_is_request) begin
          produce    = 1'b1;
          new_res    = rae_pkg::mk_res(rae_pkg::K_ARP_REPLY, p_port, p_mac, it.mac_value,
                                       it.ip_b, it.ip_a, '0, '0);
          state_next = rae_pkg::S_FLUSH;
        end else begin
          idx_next   = '0;
          state_next = rae_pkg::S_RL_RD;
        end
      end

      // Release parked packets waiting on the sender, in slot order.
      rae_pkg::S_RL_RD: begin
        if (idx >= QDEP || res_n == MAXR) begin
          if (res_n == 5'd0) begin
            produce = 1'b1;
            new_res = rae_pkg::mk_res(rae_pkg::K_DONE, '0, '0, '0, '0, '0, '0, '0);
          end
          state_next = rae_pkg::S_FLUSH;
        end else if (!wvalid[qi]) begin
          idx_next = idx + IW'(1);
        end else begin
          state_next = rae_pkg::S_RL_CMP;
        end
      end
      rae_pkg::S_RL_CMP: begin
        if (wq_rdata.hop == it.ip_a) begin
          if (can_emit) begin
            wv_clr     = 1'b1;
            produce    = 1'b1;
            new_res    = rae_pkg::mk_res(rae_pkg::K_IP_FRAME, p_port, p_mac, it.mac_value,
                                         '0, '0, it.ip_a, wq_rdata.tag);
            res_n_next = res_n + 5'd1;
            idx_next   = idx + IW'(1);
            state_next = rae_pkg::S_RL_RD;
          end
        end else begin
          idx_next   = idx + IW'(1);
          state_next = rae_pkg::S_RL_RD;
        end
      end

      rae_pkg::S_FLUSH: begin
        if (out_free) begin
          state_next = rae_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rae_pkg::S_IDLE;
      end
    endcase
  end

  // Staging register: a result goes out once the next one exists or the item ends,
  // so the final result can carry the last mark.
  always_comb begin
    stg_next       = stg;
    stg_valid_next = stg_valid;
    push           = 1'b0;
    push_res       = stg;
    if (produce) begin
      push           = stg_valid;
      stg_next       = new_res;
      stg_valid_next = 1'b1;
    end else if (state == rae_pkg::S_FLUSH && out_free) begin
      push           = 1'b1;
      push_res.last  = 1'b1;
      stg_valid_next = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rae_pkg::S_IDLE;
      stg_valid <= 1'b0;
      victim    <= '0;
      cvalid    <= '0;
      wvalid    <= '0;
    end else begin
      state     <= state_next;
      stg_valid <= stg_valid_next;
      victim    <= victim_next;
      if (cv_set) begin
        cvalid[ch_waddr] <= 1'b1;
      end
      if (wv_set) begin
        wvalid[qi] <= 1'b1;
      end
      if (wv_clr) begin
        wvalid[qi] <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    it         <= it_next;
    idx        <= idx_next;
    res_n      <= res_n_next;
    p_port     <= p_port_next;
    p_mac      <= p_mac_next;
    hop        <= hop_next;
    rport      <= rport_next;
    r_ip       <= r_ip_next;
    r_mac      <= r_mac_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    stg        <= stg_next;
  end

  // Checks on the sequencer and the staging register.
  `RAE_ASSERT(a_push_free, clk, rst, push, out_free, "result pushed into a busy output")
  `RAE_ASSERT(a_idle_empty, clk, rst, state == rae_pkg::S_IDLE, !stg_valid,
              "staged result left over in idle")
  `RAE_ASSERT_NEXT(a_acc_busy, clk, rst, in_acc, state != rae_pkg::S_IDLE,
                   "accepted item did not start work")
  `RAE_ASSERT(a_res_limit, clk, rst, 1'b1, res_n <= MAXR, "too many results for one item")

endmodule

// File: rtl/route_and_arp_resolve_engine_unit.sv
// Top level of the route and ARP resolve engine: configuration, engine and output register.
//
// Input channel (in_valid, in_stall, in_item) carries route loads, interface loads,
// packets and ARP messages; an item is taken when in_valid is high and in_stall low.
// Output channel (out_valid, out_stall, out_item) carries the results; every item
// gives one or more results, the final one with last set.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); the user must see that
// it is written only while idle, as the block does not enforce this. One item is worked at
// a time; the engine walks its table memories one entry at a time, with a memory read and
// then a compare. A packet walks the routes, reads the outgoing port address, searches the
// valid cache entries and, on a miss, looks for a free pending slot. An ARP message scans
// the ports, then the cache entries for learning, and a reply then the pending slots.
// Reset sets the configuration to routing off, no routes and one port, and clears the
// cache and pending valid bits, the cache victim pointer and all handshake state; route
// and port tables hold garbage until loaded.
// When the receiver stalls, the result holds in the output register and the engine
// holds its next result in a staging register and waits.
module route_and_arp_resolve_engine_unit #(
  parameter int ROUTE_DEPTH = rae_pkg::ROUTE_DEPTH_DEF,
  parameter int PORT_DEPTH  = rae_pkg::PORT_DEPTH_DEF,
  parameter int CACHE_DEPTH = rae_pkg::CACHE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = rae_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rae_pkg::item_in_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rae_pkg::item_out_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [4:0]         cfg_wdata
);

  rae_pkg::cfg_t      cfg;
  logic               out_free;
  logic               push;
  rae_pkg::item_out_t push_res;

  assign out_free = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.routing_enabled <= 1'b0;
      cfg.route_count     <= 5'd0;
      cfg.port_count      <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        rae_pkg::REG_ROUTING_ENABLED: cfg.routing_enabled <= cfg_wdata[0];
        rae_pkg::REG_ROUTE_COUNT:     cfg.route_count     <= cfg_wdata;
        rae_pkg::REG_PORT_COUNT:      cfg.port_count      <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  rae_engine #(
    .ROUTE_DEPTH(ROUTE_DEPTH),
    .PORT_DEPTH(PORT_DEPTH),
    .CACHE_DEPTH(CACHE_DEPTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .cfg(cfg),
    .out_free(out_free),
    .push(push),
    .push_res(push_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= push_res;
    end
  end

endmodule
